// File: src/assert_macros.svh
// Assertion macros used by flac_predictor_restore.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: src/fpr_pkg.sv
`default_nettype none
package fpr_pkg;
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_COEF     = 2'd1,
        CMD_WARMUP   = 2'd2,
        CMD_RESIDUAL = 2'd3
    } t_command;

    localparam logic KIND_FIXED = 1'b0;
    localparam logic KIND_LPC   = 1'b1;
    localparam logic [5:0] FIXED_MAX_ORDER = 6'd4;

    typedef struct packed {
        logic push;
        logic rotate;
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: src/fpr_cell.sv
`default_nettype none
module fpr_cell #(
    parameter int SAMPLE_BITS = 32,
    parameter int TAP_BITS    = 16
) (
    input  wire                     i_clk,
    input  fpr_pkg::t_cell_ctl      i_ctl,
    input  wire                     i_tap_we,
    input  wire  [TAP_BITS-1:0]     i_tap,
    input  wire  [SAMPLE_BITS-1:0]  i_prev_sample,
    input  wire  [SAMPLE_BITS-1:0]  i_next_sample,
    input  wire  [TAP_BITS-1:0]     i_next_tap,
    output logic [SAMPLE_BITS-1:0]  o_sample,
    output logic [TAP_BITS-1:0]     o_tap
);
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TAP_BITS-1:0]    r_tap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_sample <= i_prev_sample;
        end else if (i_ctl.rotate) begin
            r_sample <= i_next_sample;
        end
        if (i_tap_we) begin
            r_tap <= i_tap;
        end else if (i_ctl.rotate) begin
            r_tap <= i_next_tap;
        end
    end

    assign o_sample = r_sample;
    assign o_tap    = r_tap;
endmodule
`default_nettype wire

// File: src/flac_predictor_restore.sv
// Warm-up, fixed-predictor residual and (for a bad fixed order) start transactions
// register their result in the cycle after acceptance; an LPC residual passes
// through S_MAC, S_DRAIN and S_FINISH first. One transaction at a time; an LPC
// residual uses one multiplier walking a ring of MAX_ORDER history and tap cells.
// Reset is synchronous and active low; history and taps are not cleared.
`default_nettype none
`include "assert_macros.svh"
module flac_predictor_restore #(
    parameter int MAX_ORDER   = 32,
    parameter int SAMPLE_BITS = 32,
    parameter int TAP_BITS    = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [1:0]         i_command,
    input  wire                i_kind,
    input  wire  [5:0]         i_order,
    input  wire  signed [4:0]  i_shift,
    input  wire  [4:0]         i_wasted_bits,
    input  wire  signed [31:0] i_value,
    input  wire                i_end_of_block,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [31:0] o_sample,
    output logic               o_error,
    output logic               o_last
);
    localparam int CW = $clog2(MAX_ORDER);
    localparam int PW = TAP_BITS + SAMPLE_BITS;
    localparam int AW = PW + 6;

    typedef enum logic [1:0] {S_IDLE, S_MAC, S_DRAIN, S_FINISH} t_state;

    t_state                 r_state;
    logic                   r_kind;
    logic [5:0]             r_order;
    logic [3:0]             r_quant;
    logic [4:0]             r_wasted;
    logic [5:0]             r_tap_count;
    logic [CW-1:0]          r_cnt;
    logic signed [PW-1:0]   r_prod;
    logic                   r_prod_en;
    logic signed [AW-1:0]   r_acc;
    logic [SAMPLE_BITS-1:0] r_value;
    logic                   r_last;
    logic                   r_out_valid;
    logic signed [31:0]     r_out_sample;
    logic                   r_out_error;
    logic                   r_out_last;

    logic [SAMPLE_BITS-1:0] w_hist [MAX_ORDER];
    logic [TAP_BITS-1:0]    w_tap  [MAX_ORDER];
    fpr_pkg::t_cell_ctl     w_ctl;
    logic                   w_acc;
    logic                   w_bad;
    logic [5:0]             n_order;
    logic                   n_bad;
    logic [SAMPLE_BITS-1:0] n_fixed_pred;
    logic [SAMPLE_BITS-1:0] n_new_sample;
    logic signed [AW-1:0]   n_shifted;
    logic [SAMPLE_BITS-1:0] n_lpc_sample;
    logic [SAMPLE_BITS-1:0] n_fixed_sample;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_bad      = (r_kind == fpr_pkg::KIND_FIXED) && (r_order > fpr_pkg::FIXED_MAX_ORDER);

    always_comb begin
        n_order = i_order;
        if (i_kind == fpr_pkg::KIND_LPC && i_order > 6'(MAX_ORDER)) begin
            n_order = 6'(MAX_ORDER);
        end
        n_bad = (i_kind == fpr_pkg::KIND_FIXED) && (i_order > fpr_pkg::FIXED_MAX_ORDER);
    end

    always_comb begin
        case (r_order)
            6'd1: n_fixed_pred = w_hist[0];
            6'd2: n_fixed_pred = (w_hist[0] << 1) - w_hist[1];
            6'd3: n_fixed_pred = (w_hist[0] << 1) + w_hist[0]
                               - (w_hist[1] << 1) - w_hist[1] + w_hist[2];
            6'd4: n_fixed_pred = (w_hist[0] << 2) - (w_hist[1] << 2) - (w_hist[1] << 1)
                               + (w_hist[2] << 2) - w_hist[3];
            default: n_fixed_pred = '0;
        endcase
    end

    assign n_fixed_sample = n_fixed_pred + i_value[SAMPLE_BITS-1:0];
    assign n_shifted      = r_acc >>> r_quant;
    assign n_lpc_sample   = n_shifted[SAMPLE_BITS-1:0] + r_value;

    always_comb begin
        w_ctl.rotate = (r_state == S_MAC);
        w_ctl.push   = (r_state == S_FINISH);
        n_new_sample = n_lpc_sample;
        if (w_acc && i_command == fpr_pkg::CMD_WARMUP) begin
            w_ctl.push   = 1'b1;
            n_new_sample = i_value[SAMPLE_BITS-1:0];
        end else if (w_acc && i_command == fpr_pkg::CMD_RESIDUAL
                     && r_kind == fpr_pkg::KIND_FIXED && !w_bad) begin
            w_ctl.push   = 1'b1;
            n_new_sample = n_fixed_sample;
        end
    end

    for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
        fpr_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TAP_BITS    (TAP_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_tap_we      (w_acc && i_command == fpr_pkg::CMD_COEF
                            && r_tap_count == 6'(g)),
            .i_tap         (i_value[TAP_BITS-1:0]),
            .i_prev_sample ((g == 0) ? n_new_sample : w_hist[(g + MAX_ORDER - 1) % MAX_ORDER]),
            .i_next_sample (w_hist[(g + 1) % MAX_ORDER]),
            .i_next_tap    (w_tap[(g + 1) % MAX_ORDER]),
            .o_sample      (w_hist[g]),
            .o_tap         (w_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= fpr_pkg::KIND_FIXED;
            r_order     <= '0;
            r_quant     <= '0;
            r_wasted    <= '0;
            r_tap_count <= '0;
            r_cnt       <= '0;
            r_prod_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_out_last <= i_end_of_block;
                        unique case (fpr_pkg::t_command'(i_command))
                            fpr_pkg::CMD_START: begin
                                r_kind      <= i_kind;
                                r_order     <= n_order;
                                r_quant     <= i_shift[4] ? 4'd0 : i_shift[3:0];
                                r_wasted    <= i_wasted_bits;
                                r_tap_count <= '0;
                                if (n_bad) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_sample <= '0;
                                    r_out_error  <= 1'b1;
                                end
                            end
                            fpr_pkg::CMD_COEF: begin
                                if (r_tap_count < 6'(MAX_ORDER)) begin
                                    r_tap_count <= r_tap_count + 6'd1;
                                end
                            end
                            fpr_pkg::CMD_WARMUP: begin
                                r_out_valid  <= 1'b1;
                                r_out_sample <= 32'(signed'(i_value[SAMPLE_BITS-1:0]))
                                                << r_wasted;
                                r_out_error  <= w_bad;
                            end
                            fpr_pkg::CMD_RESIDUAL: begin
                                if (w_bad) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_sample <= '0;
                                    r_out_error  <= 1'b1;
                                end else if (r_kind == fpr_pkg::KIND_FIXED) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_sample <= 32'(signed'(n_fixed_sample)) << r_wasted;
                                    r_out_error  <= 1'b0;
                                end else begin
                                    r_state   <= S_MAC;
                                    r_cnt     <= '0;
                                    r_acc     <= '0;
                                    r_prod_en <= 1'b0;
                                    r_value   <= i_value[SAMPLE_BITS-1:0];
                                    r_last    <= i_end_of_block;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAC: begin
                    if (r_prod_en) begin
                        r_acc <= r_acc + AW'(r_prod);
                    end
                    r_prod    <= $signed(w_tap[0]) * $signed(w_hist[0]);
                    r_prod_en <= (6'(r_cnt) < r_order) && (6'(r_cnt) < r_tap_count);
                    r_cnt     <= r_cnt + CW'(1);
                    if (r_cnt == CW'(MAX_ORDER - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_prod_en) begin
                        r_acc <= r_acc + AW'(r_prod);
                    end
                    r_prod_en <= 1'b0;
                    r_state   <= S_FINISH;
                end
                S_FINISH: begin
                    r_out_valid  <= 1'b1;
                    r_out_sample <= 32'(signed'(n_lpc_sample)) << r_wasted;
                    r_out_error  <= 1'b0;
                    r_out_last   <= r_last;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_error     = r_out_error;
    assign o_last      = r_out_last;

    `ASSERT_SAME(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `ASSERT_SAME(a_busy_no_out, i_clk, i_rst_n, r_state == S_MAC, !r_out_valid)
    `ASSERT_NEXT(a_mac_ends, i_clk, i_rst_n,
        r_state == S_MAC && r_cnt == CW'(MAX_ORDER - 1), r_state == S_DRAIN)
    `ASSERT_NEXT(a_finish_out, i_clk, i_rst_n, r_state == S_FINISH, r_out_valid)
endmodule
`default_nettype wire
